// File: rtl/fwps_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the FIFO with priority slot.
package fwps_pkg;

    typedef enum logic [1:0] {
        OP_PUSH      = 2'd0,
        OP_PRIO_PUSH = 2'd1,
        OP_POP       = 2'd2,
        OP_STEAL     = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    localparam int unsigned PORT_WIDTH = 32;

endpackage

// File: rtl/fifo_with_priority_slot_top.sv
`timescale 1ns / 1ps
// Result path: push, priority push, slot pop and empty pop/steal give their result in the cycle
// after acceptance; a pop or steal served from the queue goes through the RAM read register, then the result register.
// Throughput: one transaction per cycle for pushes and slot pops while the receiver takes results;
// a read from the entry RAM, which has a single registered read port, holds off input in ST_READ.
// Reset (synchronous, active low) clears the pointers, the priority slot and the output
// valid; the entry RAM is not cleared, since only written entries are ever read.
module fifo_with_priority_slot_top
    import fwps_pkg::*;
#(
    parameter int LOG_DEPTH     = 6,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_opcode,
    input  logic [PORT_WIDTH-1:0] i_element,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PORT_WIDTH-1:0] o_out_element,
    output logic                  o_got_element,
    output logic                  o_overflow
);

    localparam int DEPTH = 1 << LOG_DEPTH;
    localparam int PTR_W = LOG_DEPTH + 1;

    t_state r_state, n_state;

    logic [PTR_W-1:0]         r_head, n_head;
    logic [PTR_W-1:0]         r_tail, n_tail;
    logic [ELEMENT_WIDTH-1:0] r_slot, n_slot;

    logic                     r_out_valid, n_out_valid;
    logic [PORT_WIDTH-1:0]    r_out_element, n_out_element;
    logic                     r_got, n_got;
    logic                     r_ovf, n_ovf;

    logic [ELEMENT_WIDTH-1:0] mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0] r_rd_data;
    logic                     mem_we;
    logic [LOG_DEPTH-1:0]     mem_waddr;
    logic [ELEMENT_WIDTH-1:0] mem_wdata;
    logic                     mem_re;

    logic                     in_fire;
    logic                     out_fire;
    logic [PTR_W-1:0]         fill;
    logic                     q_full;
    logic                     q_empty;
    logic                     slot_busy;
    logic                     head_read;
    logic [ELEMENT_WIDTH-1:0] elem_in;
    t_opcode                  op;

    assign op        = t_opcode'(i_opcode);
    assign elem_in   = ELEMENT_WIDTH'(i_element);
    assign fill      = r_tail - r_head;
    assign q_full    = fill[LOG_DEPTH];
    assign q_empty   = (fill == '0);
    assign slot_busy = (r_slot != '0);

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;

    // Pop falls through to the queue only when the slot is empty.
    assign head_read = in_fire && !q_empty &&
                       ((op == OP_STEAL) || ((op == OP_POP) && !slot_busy));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (head_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM read enable; the result is loaded from the read data in ST_READ by the block below.
    always_comb begin
        mem_re = 1'b0;
        unique case (r_state)
            ST_IDLE: mem_re = head_read;
            ST_READ: mem_re = 1'b0;
            default: mem_re = 1'b0;
        endcase
    end

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_slot        = r_slot;
        n_out_valid   = r_out_valid && !out_fire;
        n_out_element = r_out_element;
        n_got         = r_got;
        n_ovf         = r_ovf;
        mem_we        = 1'b0;
        mem_waddr     = r_tail[LOG_DEPTH-1:0];
        mem_wdata     = elem_in;

        if (r_state == ST_READ) begin
            n_out_valid   = 1'b1;
            n_out_element = PORT_WIDTH'(r_rd_data);
            n_got         = 1'b1;
            n_ovf         = 1'b0;
        end else if (in_fire) begin
            n_out_element = '0;
            n_got         = 1'b0;
            n_ovf         = 1'b0;
            case (op)
                OP_PUSH: begin
                    n_out_valid = 1'b1;
                    if (q_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_tail = r_tail + PTR_W'(1);
                    end
                end
                OP_PRIO_PUSH: begin
                    n_out_valid = 1'b1;
                    if (!slot_busy) begin
                        n_slot = elem_in;
                    end else if (q_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = r_slot;
                        n_tail    = r_tail + PTR_W'(1);
                        n_slot    = elem_in;
                    end
                end
                OP_POP, OP_STEAL: begin
                    if ((op == OP_POP) && slot_busy) begin
                        n_out_valid   = 1'b1;
                        n_out_element = PORT_WIDTH'(r_slot);
                        n_got         = 1'b1;
                        n_slot        = '0;
                    end else if (q_empty) begin
                        n_out_valid = 1'b1;
                    end else begin
                        // The result is loaded when the RAM data returns.
                        n_head = r_head + PTR_W'(1);
                    end
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_head[LOG_DEPTH-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_element <= n_out_element;
        r_got         <= n_got;
        r_ovf         <= n_ovf;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_element = r_out_element;
    assign o_got_element = r_got;
    assign o_overflow    = r_ovf;

endmodule

// File: rtl/fwps_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the FIFO with priority slot, bound to the top level.
module fwps_checker
    import fwps_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [1:0]            i_opcode,
    input logic [PORT_WIDTH-1:0] i_element,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PORT_WIDTH-1:0] o_out_element,
    input logic                  o_got_element,
    input logic                  o_overflow
);

    logic in_fire;
    logic is_push;

    assign in_fire = i_in_valid && o_in_ready;
    assign is_push = (i_opcode == OP_PUSH) || (i_opcode == OP_PRIO_PUSH);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_element))
        else $error("result changed while stalled");

    // A new result only appears following an accepted transaction, directly or through the entry RAM read.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_fire) || $past(in_fire, 2))
        else $error("result without a transaction");

    // A push of either kind answers in the next cycle and never returns an element.
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && is_push |=> o_out_valid && !o_got_element && (o_out_element == '0))
        else $error("bad push result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_got_element && o_overflow))
        else $error("got and overflow both set");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_got_element |-> (o_out_element == '0))
        else $error("element returned without got flag");

endmodule

bind fifo_with_priority_slot_top fwps_checker u_fwps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .i_element     (i_element),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_element (o_out_element),
    .o_got_element (o_got_element),
    .o_overflow    (o_overflow)
);

// File: sim/tb_fifo_with_priority_slot_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FIFO with priority slot under directed and random traffic.
module tb_fifo_with_priority_slot_top;
    import fwps_pkg::*;

    localparam int LOG_DEPTH     = 6;
    localparam int ELEMENT_WIDTH = 32;
    localparam int QDEPTH        = 1 << LOG_DEPTH;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] elem;
        logic                  got;
        logic                  ovf;
    } t_qresult;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [1:0]            opcode      = OP_PUSH;
    logic [PORT_WIDTH-1:0] element     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [PORT_WIDTH-1:0] out_element;
    logic                  got_element;
    logic                  overflow;

    // Model of the queue, updated once per accepted transaction.
    logic [ELEMENT_WIDTH-1:0] mdl_store [QDEPTH];
    logic [LOG_DEPTH:0]       mdl_head = '0;
    logic [LOG_DEPTH:0]       mdl_tail = '0;
    logic [ELEMENT_WIDTH-1:0] mdl_slot = '0;

    t_qresult pending_results[$];
    int       err_count     = 0;
    int       rx_stall_pct  = 0;
    int       hold_requests = 0;
    int       op_count[4]   = '{0, 0, 0, 0};
    int       ovf_count     = 0;
    int       empty_count   = 0;

    fifo_with_priority_slot_top #(
        .LOG_DEPTH    (LOG_DEPTH),
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_opcode     (opcode),
        .i_element    (element),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_element(out_element),
        .o_got_element(got_element),
        .o_overflow   (overflow)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_qresult queue_model_step(input t_opcode op,
                                                  input logic [PORT_WIDTH-1:0] value);
        t_qresult           res;
        logic [LOG_DEPTH:0] fill;
        logic               full;
        logic               take;
        res  = '0;
        fill = mdl_tail - mdl_head;
        full = (fill >= QDEPTH);
        take = 1'b0;
        op_count[op]++;
        case (op)
            OP_PUSH: begin
                if (full) begin
                    res.ovf = 1'b1;
                end else begin
                    mdl_store[mdl_tail[LOG_DEPTH-1:0]] = value;
                    mdl_tail = mdl_tail + 1'b1;
                end
            end
            OP_PRIO_PUSH: begin
                if (mdl_slot != '0) begin
                    if (full) begin
                        res.ovf = 1'b1;
                    end else begin
                        // The displaced slot element goes to the tail.
                        mdl_store[mdl_tail[LOG_DEPTH-1:0]] = mdl_slot;
                        mdl_tail = mdl_tail + 1'b1;
                        mdl_slot = value;
                    end
                end else begin
                    mdl_slot = value;
                end
            end
            OP_POP: begin
                if (mdl_slot != '0) begin
                    res.elem = mdl_slot;
                    res.got  = 1'b1;
                    mdl_slot = '0;
                end else begin
                    take = 1'b1;
                end
            end
            OP_STEAL: begin
                take = 1'b1;
            end
        endcase
        if (take) begin
            if (fill != '0) begin
                res.elem = mdl_store[mdl_head[LOG_DEPTH-1:0]];
                res.got  = 1'b1;
                mdl_head = mdl_head + 1'b1;
            end else begin
                empty_count++;
            end
        end
        if (res.ovf) ovf_count++;
        return res;
    endfunction

    function automatic logic [PORT_WIDTH-1:0] rand_element();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return '0;
        if (pick < 13) return '1;
        if (pick < 18) return 32'h1 << $urandom_range(31);
        return $urandom;
    endfunction

    task automatic send_item(input t_opcode op, input logic [PORT_WIDTH-1:0] value);
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        element  <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(queue_model_step(op, value));
    endtask

    // Idle cycles carry junk payload, which the block must ignore.
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid <= 1'b0;
            opcode   <= 2'($urandom_range(3));
            element  <= $urandom;
        end
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        rx_stall_pct = 20;
        send_item(OP_POP, '0);
        send_item(OP_STEAL, '0);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'h0000_0001);
        send_item(OP_POP, '0);
        // A zero entry comes back with got_element set.
        send_item(OP_STEAL, '0);
        send_item(OP_PRIO_PUSH, 32'h8000_0000);
        send_item(OP_PRIO_PUSH, 32'h1234_5678);
        send_item(OP_STEAL, '0);
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        send_item(OP_PRIO_PUSH, 32'h0000_0000);
        send_item(OP_POP, '0);
        send_item(OP_PRIO_PUSH, 32'hA5A5_A5A5);
        // A zero priority push still moves the old slot element to the tail.
        send_item(OP_PRIO_PUSH, 32'h0000_0000);
        send_item(OP_STEAL, '0);
        send_item(OP_PRIO_PUSH, 32'h5A5A_5A5A);
        send_item(OP_STEAL, '0);
        send_item(OP_POP, '0);
        send_item(OP_PUSH, 32'h7FFF_FFFF);
        send_item(OP_POP, '0);
        idle_sender(2);
        wait_drain();
    endtask

    task automatic test_full_backpressure();
        rx_stall_pct = 0;
        hold_requests++;
        // The receiver holds off while pushes keep coming, so the block stalls its input.
        for (int i = 0; i < QDEPTH + 6; i++) begin
            send_item(OP_PUSH, rand_element() | 32'h1);
        end
        send_item(OP_PRIO_PUSH, 32'hC0DE_0001);
        send_item(OP_PRIO_PUSH, 32'hC0DE_0002);
        send_item(OP_PUSH, 32'hC0DE_0003);
        send_item(OP_POP, '0);
        for (int i = 0; i < QDEPTH; i++) begin
            send_item(OP_STEAL, '0);
        end
        send_item(OP_POP, '0);
        idle_sender(1);
        wait_drain();
    endtask

    task automatic test_random(input int n_items, input int stall_pct, input int max_gap);
        int      sent;
        int      burst;
        int      bias;
        int      r;
        t_opcode op;
        sent = 0;
        rx_stall_pct = stall_pct;
        while (sent < n_items) begin
            burst = $urandom_range(1, 16);
            bias  = $urandom_range(2);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                r = $urandom_range(99);
                case (bias)
                    0: op = (r < 55) ? OP_PUSH : (r < 75) ? OP_PRIO_PUSH :
                            (r < 90) ? OP_POP : OP_STEAL;
                    1: op = (r < 15) ? OP_PUSH : (r < 25) ? OP_PRIO_PUSH :
                            (r < 65) ? OP_POP : OP_STEAL;
                    default: op = t_opcode'(r % 4);
                endcase
                send_item(op, rand_element());
                sent++;
            end
            if (max_gap > 0) idle_sender($urandom_range(max_gap));
        end
        idle_sender(1);
        wait_drain();
    endtask

    // Receiver: random ready runs, plus a long hold-off whenever one is requested.
    initial begin : rx_driver
        int run_left;
        int hold_left;
        int holds_served;
        bit rdy;
        run_left     = 0;
        hold_left    = 0;
        holds_served = 0;
        rdy          = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    rdy      = ($urandom_range(99) >= rx_stall_pct);
                    run_left = $urandom_range(1, 6);
                end
                run_left--;
                out_ready <= rdy;
            end
        end
    end

    always @(posedge clk) begin
        t_qresult want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction pending: out_element %h", out_element);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_element !== want.elem) begin
                    $error("out_element: expected %h, actual %h", want.elem, out_element);
                    err_count++;
                end
                if (got_element !== want.got) begin
                    $error("got_element: expected %b, actual %b", want.got, got_element);
                    err_count++;
                end
                if (overflow !== want.ovf) begin
                    $error("overflow: expected %b, actual %b", want.ovf, overflow);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_backpressure();
        test_random(60, 0, 0);
        test_random(100, 30, 4);
        test_random(100, 60, 8);
        test_random(30, 10, 2);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d transactions: %0d push, %0d priority push, %0d pop, %0d steal.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Saw %0d refused appends, %0d removals from an empty queue, %0d long stalls.",
                 ovf_count, empty_count, hold_requests);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: fifo_with_priority_slot_top.f
rtl/fwps_pkg.sv
rtl/fifo_with_priority_slot_top.sv
rtl/fwps_checker.sv
sim/tb_fifo_with_priority_slot_top.sv
